// ===== sv/bounded_top_k_table_macros.svh =====
// Assertion macros for the ranking table sequencer, btk_ctrl.
// Needs a clock named aclk and an active-low reset named aresetn in the including scope.
`ifndef BOUNDED_TOP_K_TABLE_MACROS_SVH
`define BOUNDED_TOP_K_TABLE_MACROS_SVH

// A condition that must hold at every clock edge outside reset.
`define BTK_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (cond)) else $error(msg);

// A property with an explicit antecedent and consequent.
`define BTK_ASSERT_PROP(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

`endif

// ===== sv/btk_pkg.sv =====
// Shared types and constants of the bounded ranking table.
// No dependencies; used by btk_cell, btk_ctrl and bounded_top_k_table.
package btk_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int KIND_W   = 2;
    localparam int ID_W     = 64;
    localparam int SCORE_W  = 50;
    localparam int FILL_W   = 7;

    localparam int S_TDATA_W = ((ID_W + SCORE_W + 7) / 8) * 8;
    localparam int M_FIELD_W = 3 + ID_W + FILL_W + SCORE_W;
    localparam int M_TDATA_W = ((M_FIELD_W + 7) / 8) * 8;

    localparam logic [SCORE_W-1:0] LIMIT_RESET = SCORE_W'(64'd1000000000000000);

    localparam logic [KIND_W-1:0] KIND_ADD    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_UPDATE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_DELETE = 2'd2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_REMOVE,
        ST_INSERT,
        ST_REPORT
    } state_t;

    typedef enum logic [1:0] {
        OP_HOLD,
        OP_REMOVE,
        OP_INSERT
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [ID_W-1:0]     key;
        logic [SCORE_W-1:0]  score;
    } cell_cmd_t;

    typedef struct packed {
        logic                valid;
        logic [ID_W-1:0]     id;
        logic [SCORE_W-1:0]  score;
    } slot_t;

    typedef struct packed {
        logic                hit;
        logic                full;
        logic                last_ge;
        logic [ID_W-1:0]     last_id;
        logic [SCORE_W-1:0]  lowest;
    } chain_stat_t;

endpackage

// ===== sv/bounded_top_k_table.sv =====
// Top level of the bounded ranking table: a chain of slot cells and its sequencer.
// Depends on btk_pkg, btk_cell and btk_ctrl.
//
// The block keeps up to CAPACITY (id, score) entries in descending score order,
// older entries first among equal scores. Each input item on the s_ channel is
// an add, update or delete selected by s_tuser; an add of an id already held
// acts as an update. Each item gives exactly one result item on the m_ channel
// with the insert, remove and evict flags, the evicted id, the fill count and
// the lowest score that remains.
// An item passes through these steps: the accepting cycle, a remove pass through the
// cell chain, an insert pass, and a report step that gathers the lowest score into
// the result register, which raises m_tvalid in the cycle after. The next item
// is taken only once the report step is done and the block is back in idle.
// The result register parts the two sides, so a new item is accepted while a
// result still waits; a stalled receiver holds the block only once a second
// result is ready. After reset the table is empty, the score limit holds its
// reset value, and no result is pending. The limit may be rewritten through
// cfg_wr_en and cfg_wr_data while the block is idle.
module bounded_top_k_table (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [btk_pkg::SCORE_W-1:0]     cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // Fields from bit 0: entry_id (64), score (50), zero fill.
    input  logic [btk_pkg::S_TDATA_W-1:0]   s_tdata,
    // Fields from bit 0: kind (2).
    input  logic [btk_pkg::KIND_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // Fields from bit 0: inserted, removed, evicted, evicted_id (64),
    // fill_count (7), lowest_score (50), zero fill.
    output logic [btk_pkg::M_TDATA_W-1:0]   m_tdata
);
    import btk_pkg::*;

    cell_cmd_t   cmd;
    chain_stat_t stat;
    slot_t       slots [CAPACITY];
    slot_t       prev_slots [CAPACITY];
    slot_t       next_slots [CAPACITY];
    logic        ge [CAPACITY];
    logic        prev_ge [CAPACITY];
    logic        hit_chain [CAPACITY+1];
    logic [SCORE_W-1:0] lowest;

    // The remove match ripples from the head toward the tail; entries move
    // up toward the head on a remove and down toward the tail on an insert.
    assign hit_chain[0] = 1'b0;

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        if (i == 0) begin : g_head
            assign prev_slots[i] = '0;
            assign prev_ge[i]    = 1'b1;
        end else begin : g_body
            assign prev_slots[i] = slots[i-1];
            assign prev_ge[i]    = ge[i-1];
        end
        if (i == CAPACITY - 1) begin : g_tail
            assign next_slots[i] = '0;
        end else begin : g_inner
            assign next_slots[i] = slots[i+1];
        end

        btk_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .cmd       (cmd),
            .prev_slot (prev_slots[i]),
            .prev_ge   (prev_ge[i]),
            .next_slot (next_slots[i]),
            .hit_in    (hit_chain[i]),
            .slot      (slots[i]),
            .ge        (ge[i]),
            .hit_out   (hit_chain[i+1])
        );
    end

    // The last valid cell is the only one whose successor is empty.
    always_comb begin
        lowest = '0;
        for (int i = 0; i < CAPACITY; i++) begin
            if (slots[i].valid && !next_slots[i].valid) begin
                lowest = lowest | slots[i].score;
            end
        end
    end

    assign stat.hit     = hit_chain[CAPACITY];
    assign stat.full    = slots[CAPACITY-1].valid;
    assign stat.last_ge = ge[CAPACITY-1];
    assign stat.last_id = slots[CAPACITY-1].id;
    assign stat.lowest  = lowest;

    btk_ctrl u_ctrl (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cmd         (cmd),
        .stat        (stat)
    );

endmodule

// ===== sv/btk_cell.sv =====
// One slot of the ranking chain: holds an entry and trades it with its neighbors.
// Depends on btk_pkg.
module btk_cell (
    input  logic               aclk,
    input  logic               aresetn,
    input  btk_pkg::cell_cmd_t cmd,
    input  btk_pkg::slot_t     prev_slot,
    input  logic               prev_ge,
    input  btk_pkg::slot_t     next_slot,
    input  logic               hit_in,
    output btk_pkg::slot_t     slot,
    output logic               ge,
    output logic               hit_out
);
    import btk_pkg::*;

    logic                valid_reg, valid_next;
    logic [ID_W-1:0]     id_reg, id_next;
    logic [SCORE_W-1:0]  score_reg, score_next;

    // The entries are sorted, so ge forms a run of ones from the head.
    assign ge      = valid_reg && (score_reg >= cmd.score);
    assign hit_out = hit_in || (valid_reg && (id_reg == cmd.key));
    assign slot    = '{valid: valid_reg, id: id_reg, score: score_reg};

    always_comb begin
        valid_next = valid_reg;
        id_next    = id_reg;
        score_next = score_reg;
        case (cmd.op)
            OP_REMOVE: begin
                // At or below the matching slot everything moves up by one.
                if (hit_out) begin
                    valid_next = next_slot.valid;
                    id_next    = next_slot.id;
                    score_next = next_slot.score;
                end
            end
            OP_INSERT: begin
                if (!ge) begin
                    if (prev_ge) begin
                        valid_next = 1'b1;
                        id_next    = cmd.key;
                        score_next = cmd.score;
                    end else begin
                        valid_next = prev_slot.valid;
                        id_next    = prev_slot.id;
                        score_next = prev_slot.score;
                    end
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        id_reg    <= id_next;
        score_reg <= score_next;
    end

endmodule

// ===== sv/btk_ctrl.sv =====
// Sequencer of the ranking table: input capture, remove and insert passes, result register.
// Depends on btk_pkg and bounded_top_k_table_macros.svh.
`include "bounded_top_k_table_macros.svh"

module btk_ctrl (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [btk_pkg::SCORE_W-1:0]     cfg_wr_data,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [btk_pkg::S_TDATA_W-1:0]   s_tdata,
    input  logic [btk_pkg::KIND_W-1:0]      s_tuser,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [btk_pkg::M_TDATA_W-1:0]   m_tdata,
    output btk_pkg::cell_cmd_t              cmd,
    input  btk_pkg::chain_stat_t            stat
);
    import btk_pkg::*;

    state_t               state_reg, state_next;
    logic [KIND_W-1:0]    kind_reg;
    logic [ID_W-1:0]      id_reg;
    logic [SCORE_W-1:0]   score_reg;
    logic [SCORE_W-1:0]   limit_reg;
    logic [CNT_W-1:0]     count_reg;
    logic                 removed_reg, inserted_reg, evicted_reg;
    logic [ID_W-1:0]      evid_reg;
    logic                 out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg;
    logic                 ins_ok, has_remove, has_insert, load_out;

    assign has_remove = (kind_reg == KIND_ADD) || (kind_reg == KIND_UPDATE)
                     || (kind_reg == KIND_DELETE);
    assign has_insert = (kind_reg == KIND_ADD) || (kind_reg == KIND_UPDATE);
    assign ins_ok     = (score_reg <= limit_reg) && !(stat.full && stat.last_ge);
    assign load_out   = (state_reg == ST_REPORT) && (!out_valid_reg || m_tready);

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (s_tvalid) state_next = ST_REMOVE;
            ST_REMOVE: state_next = ST_INSERT;
            ST_INSERT: state_next = ST_REPORT;
            ST_REPORT: if (!out_valid_reg || m_tready) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = 1'b0;
        cmd.op    = OP_HOLD;
        cmd.key   = id_reg;
        cmd.score = score_reg;
        case (state_reg)
            ST_IDLE:   s_tready = 1'b1;
            ST_REMOVE: if (has_remove) cmd.op = OP_REMOVE;
            ST_INSERT: if (has_insert && ins_ok) cmd.op = OP_INSERT;
            default: begin
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            limit_reg     <= LIMIT_RESET;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                limit_reg <= cfg_wr_data;
            end
            if (cmd.op == OP_REMOVE && stat.hit) begin
                count_reg <= count_reg - CNT_W'(1);
            end else if (cmd.op == OP_INSERT && !stat.full) begin
                count_reg <= count_reg + CNT_W'(1);
            end
            if (load_out) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            kind_reg     <= s_tuser;
            id_reg       <= s_tdata[ID_W-1:0];
            score_reg    <= s_tdata[ID_W +: SCORE_W];
            removed_reg  <= 1'b0;
            inserted_reg <= 1'b0;
            evicted_reg  <= 1'b0;
            evid_reg     <= '0;
        end
        if (cmd.op == OP_REMOVE) begin
            removed_reg <= stat.hit;
        end
        if (cmd.op == OP_INSERT) begin
            inserted_reg <= 1'b1;
            if (stat.full) begin
                evicted_reg <= 1'b1;
                evid_reg    <= stat.last_id;
            end
        end
        if (load_out) begin
            out_data_reg <= M_TDATA_W'({stat.lowest, FILL_W'(count_reg), evid_reg,
                                        evicted_reg, removed_reg, inserted_reg});
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    `BTK_ASSERT(a_count_bound, count_reg <= CNT_W'(CAPACITY), "entry count above capacity")
    `BTK_ASSERT_PROP(a_accept_starts, (s_tvalid && s_tready) |=> (state_reg == ST_REMOVE),
        "accepted item did not start the remove pass")
    `BTK_ASSERT_PROP(a_evict_inserts, (state_reg == ST_REPORT && evicted_reg) |-> inserted_reg,
        "eviction reported without an insert")
    `BTK_ASSERT_PROP(a_grow_count, (cmd.op == OP_INSERT && !stat.full) |=>
        (count_reg == $past(count_reg) + CNT_W'(1)), "insert into free slot lost the count")

endmodule

// ===== verif/tb_bounded_top_k_table.sv =====
`timescale 1ns / 1ps
// Self-checking testbench for the bounded ranking table (bounded_top_k_table).
// Depends on btk_pkg and the RTL of the block; a scoreboard class predicts each result.
module tb_bounded_top_k_table;
    import btk_pkg::*;

    // The fourth kind code is not an operation; the block must leave the table alone.
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [SCORE_W-1:0] SCORE_MAX = '1;
    // The slowest correct run covers the longest send gap, the block's own steps and
    // the longest receive stall for each of about 2000 items, plus pauses.
    localparam int CYCLE_LIMIT = 500000;
    localparam int PHASE_ITEMS = 325;
    localparam int ID_POOL = 96;
    localparam int TIE_POOL = 8;

    logic                   aclk = 1'b0;
    logic                   aresetn;
    logic                   cfg_wr_en;
    logic [SCORE_W-1:0]     cfg_wr_data;
    logic                   s_tvalid;
    logic                   s_tready;
    // Fields from bit 0: entry_id (64), score (50), zero fill.
    logic [S_TDATA_W-1:0]   s_tdata;
    // Fields from bit 0: kind (2).
    logic [KIND_W-1:0]      s_tuser;
    logic                   m_tvalid;
    logic                   m_tready;
    // Fields from bit 0: inserted, removed, evicted, evicted_id (64),
    // fill_count (7), lowest_score (50), zero fill.
    logic [M_TDATA_W-1:0]   m_tdata;

    // One result item as the block should report it.
    typedef struct {
        bit                 inserted;
        bit                 removed;
        bit                 evicted;
        bit [ID_W-1:0]      evicted_id;
        bit [FILL_W-1:0]    fill_count;
        bit [SCORE_W-1:0]   lowest_score;
    } rank_outcome_t;

    // Keeps its own copy of the ranking table and the score limit, works out the
    // outcome of every accepted item and checks the results in order.
    class rank_tracker;
        bit [SCORE_W-1:0]   score_limit;
        bit [SCORE_W-1:0]   slot_score [CAPACITY];
        bit [ID_W-1:0]      slot_id [CAPACITY];
        int                 held;
        rank_outcome_t      pending_outcomes [$];
        int                 failures;

        function new();
            score_limit = LIMIT_RESET;
            held = 0;
            failures = 0;
        endfunction

        function void set_limit(bit [SCORE_W-1:0] value);
            score_limit = value;
        endfunction

        function void note_item(logic [KIND_W-1:0] kind, bit [ID_W-1:0] id,
                                bit [SCORE_W-1:0] score);
            rank_outcome_t outcome;
            int i;
            int pos;
            bit room;
            outcome = '{default: 0};
            if (kind != KIND_UNUSED) begin
                // Every real operation first drops the id if it is held.
                pos = -1;
                for (i = 0; i < held && pos < 0; i++)
                    if (slot_id[i] == id) pos = i;
                if (pos >= 0) begin
                    for (i = pos; i < held - 1; i++) begin
                        slot_score[i] = slot_score[i + 1];
                        slot_id[i] = slot_id[i + 1];
                    end
                    held--;
                    outcome.removed = 1'b1;
                end
            end
            if ((kind == KIND_ADD || kind == KIND_UPDATE) && score <= score_limit) begin
                room = 1'b1;
                if (held == CAPACITY) begin
                    // A full table only takes a score strictly above its lowest one.
                    if (score > slot_score[CAPACITY - 1]) begin
                        outcome.evicted = 1'b1;
                        outcome.evicted_id = slot_id[CAPACITY - 1];
                        held--;
                    end else begin
                        room = 1'b0;
                    end
                end
                if (room) begin
                    // Equal scores keep their order, so the newcomer goes after them.
                    pos = 0;
                    while (pos < held && slot_score[pos] >= score) pos++;
                    for (i = held; i > pos; i--) begin
                        slot_score[i] = slot_score[i - 1];
                        slot_id[i] = slot_id[i - 1];
                    end
                    slot_score[pos] = score;
                    slot_id[pos] = id;
                    held++;
                    outcome.inserted = 1'b1;
                end
            end
            outcome.fill_count = FILL_W'(held);
            outcome.lowest_score = (held > 0) ? slot_score[held - 1] : '0;
            pending_outcomes.push_back(outcome);
        endfunction

        function void compare_field(string field_name, logic [63:0] want, logic [63:0] got);
            if (got !== want) begin
                $error("%s mismatch: expected %0h, actual %0h", field_name, want, got);
                failures++;
            end
        endfunction

        function void check_result(logic [M_TDATA_W-1:0] data);
            rank_outcome_t want;
            if (pending_outcomes.size() == 0) begin
                $error("result item with no outcome pending: %0h", data);
                failures++;
            end else begin
                want = pending_outcomes.pop_front();
                compare_field("inserted", 64'(want.inserted), 64'(data[0]));
                compare_field("removed", 64'(want.removed), 64'(data[1]));
                compare_field("evicted", 64'(want.evicted), 64'(data[2]));
                compare_field("evicted_id", want.evicted_id, data[3 +: ID_W]);
                compare_field("fill_count", 64'(want.fill_count),
                              64'(data[3 + ID_W +: FILL_W]));
                compare_field("lowest_score", 64'(want.lowest_score),
                              64'(data[3 + ID_W + FILL_W +: SCORE_W]));
            end
        endfunction
    endclass

    rank_tracker tracker = new();

    logic [ID_W-1:0]    id_pool [ID_POOL];
    logic [SCORE_W-1:0] tie_scores [TIE_POOL];
    // While a steady flag is set that side neither idles nor stalls.
    bit                 send_steady = 1'b0;
    bit                 recv_steady = 1'b0;
    int                 cycle_count = 0;

    bounded_top_k_table dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Watchdog: a run that hangs on a handshake ends here.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Results are taken at the rising edge, where the handshake is decided.
    always @(posedge aclk) begin
        if (aresetn && m_tvalid && m_tready)
            tracker.check_result(m_tdata);
    end

    // Receiver: before each result it stalls for a random number of cycles,
    // then holds tready high until that result has been taken.
    initial begin
        int stall;
        m_tready = 1'b0;
        wait (aresetn === 1'b1);
        forever begin
            @(negedge aclk);
            if ($urandom_range(0, 47) == 0) recv_steady = !recv_steady;
            stall = recv_steady ? 0 : $urandom_range(0, 16);
            if (stall > 0) begin
                m_tready = 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_tready = 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    // Sends one item. It is entered at a falling edge and returns at the falling
    // edge after the item was accepted, with tvalid still high so that a
    // following item can go out back to back.
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [ID_W-1:0] id,
                             input logic [SCORE_W-1:0] score);
        int gap;
        gap = send_steady ? 0 : $urandom_range(0, 16);
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tuser = kind;
        s_tdata = S_TDATA_W'({score, id});
        do @(posedge aclk); while (!s_tready);
        tracker.note_item(kind, id, score);
        @(negedge aclk);
    endtask

    // Holds the sender back until every pending result has come out.
    task automatic wait_for_outcomes();
        s_tvalid = 1'b0;
        while (tracker.pending_outcomes.size() != 0) @(negedge aclk);
    endtask

    // The limit is only changed while the block is idle. Every item gives a
    // result, so a short pause after the last one covers the block's latency.
    task automatic write_limit(input logic [SCORE_W-1:0] value);
        wait_for_outcomes();
        repeat (8) @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_wr_data = value;
        @(negedge aclk);
        cfg_wr_en = 1'b0;
        tracker.set_limit(value);
    endtask

    function automatic logic [SCORE_W-1:0] draw_score();
        logic [63:0] raw;
        logic [SCORE_W-1:0] limit;
        limit = tracker.score_limit;
        raw = {$urandom, $urandom};
        case ($urandom_range(0, 9))
            0: return '0;
            1: return limit;
            // Just above the limit; wraps to zero when the limit is the maximum.
            2: return limit + 1'b1;
            3: return SCORE_MAX;
            4, 5, 6: return tie_scores[$urandom_range(0, TIE_POOL - 1)];
            default: return SCORE_W'(raw % (64'(limit) + 64'd1));
        endcase
    endfunction

    function automatic logic [ID_W-1:0] draw_id();
        if ($urandom_range(0, 9) == 0) return {$urandom, $urandom};
        return id_pool[$urandom_range(0, ID_POOL - 1)];
    endfunction

    // A phase of random items. The id pool is larger than the table, so adds
    // keep it near full and evictions happen; repeated ids exercise updates.
    task automatic run_random_phase(input int count);
        int n;
        int pick;
        logic [63:0] raw;
        logic [KIND_W-1:0] kind;
        for (n = 0; n < TIE_POOL; n++) begin
            raw = {$urandom, $urandom};
            tie_scores[n] = SCORE_W'(raw % (64'(tracker.score_limit) + 64'd1));
        end
        for (n = 0; n < count; n++) begin
            if ($urandom_range(0, 63) == 0) send_steady = !send_steady;
            if ($urandom_range(0, 149) == 0) wait_for_outcomes();
            pick = $urandom_range(0, 99);
            if (pick < 50) kind = KIND_ADD;
            else if (pick < 75) kind = KIND_UPDATE;
            else if (pick < 95) kind = KIND_DELETE;
            else kind = KIND_UNUSED;
            send_item(kind, draw_id(), draw_score());
        end
    endtask

    initial begin
        int p;
        logic [SCORE_W-1:0] phase_limit [5];
        aresetn = 1'b0;
        cfg_wr_en = 1'b0;
        cfg_wr_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        s_tuser = KIND_ADD;
        for (p = 0; p < ID_POOL; p++) id_pool[p] = {$urandom, $urandom};
        for (p = 0; p < TIE_POOL; p++) tie_scores[p] = SCORE_W'($urandom);

        // Synchronous reset, asserted from the start and released once.
        repeat (3) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // Directed items under the reset limit.
        send_item(KIND_DELETE, id_pool[0], '0);              // delete on an empty table
        send_item(KIND_UNUSED, id_pool[0], 50'd77);          // unused kind, empty table
        send_item(KIND_ADD, id_pool[0], 50'd500);
        send_item(KIND_ADD, id_pool[1], 50'd500);            // equal score goes after
        send_item(KIND_ADD, id_pool[2], LIMIT_RESET);        // exactly at the limit
        send_item(KIND_ADD, id_pool[3], LIMIT_RESET + 1'b1); // just above the limit
        send_item(KIND_ADD, id_pool[4], SCORE_MAX);          // far above the limit
        send_item(KIND_ADD, '1, '0);                         // largest id, zero score
        send_item(KIND_ADD, '0, 50'd500);                    // id zero, another tie
        send_item(KIND_UPDATE, id_pool[0], 50'd700);
        send_item(KIND_UPDATE, id_pool[5], 50'd100);         // update of an absent id
        send_item(KIND_ADD, id_pool[1], 50'd900);            // add of a held id
        send_item(KIND_UPDATE, id_pool[2], SCORE_MAX);       // removed, then rejected
        send_item(KIND_DELETE, id_pool[5], '0);
        send_item(KIND_DELETE, id_pool[5], '0);              // already gone
        send_item(KIND_UNUSED, id_pool[1], SCORE_MAX);       // unused kind, non-empty table
        send_item(KIND_ADD, {32{2'b10}}, {25{2'b10}});
        send_item(KIND_ADD, {32{2'b01}}, {25{2'b01}});
        send_item(KIND_UPDATE, '1, '0);                      // same score again
        send_item(KIND_DELETE, '0, SCORE_MAX);

        // Random phases, the first under the reset limit, then one per setting.
        phase_limit[0] = SCORE_MAX;
        phase_limit[1] = '0;
        phase_limit[2] = 50'd5000;
        phase_limit[3] = SCORE_W'({$urandom, $urandom});
        phase_limit[4] = LIMIT_RESET;
        run_random_phase(PHASE_ITEMS);
        for (p = 0; p < 5; p++) begin
            write_limit(phase_limit[p]);
            run_random_phase(PHASE_ITEMS);
        end

        wait_for_outcomes();
        repeat (16) @(posedge aclk);
        if (tracker.pending_outcomes.size() != 0) begin
            $error("%0d results never arrived", tracker.pending_outcomes.size());
            tracker.failures++;
        end
        if (tracker.failures == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
+incdir+sv
sv/btk_pkg.sv
sv/btk_cell.sv
sv/btk_ctrl.sv
sv/bounded_top_k_table.sv
verif/tb_bounded_top_k_table.sv
